@@ hdl/uer_pkg.sv @@
// Shared widths, register defaults and constants for the echo ranger.
package uer_pkg;

    localparam int TRIG_W  = 8;
    localparam int CNT_W   = 16;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 17;
    localparam int SUM_W   = 24;
    localparam int IDX_W   = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W  = CNT_W + SCALE_W;
    localparam int FRAC_SHIFT = 8;

    // Number of distances per averaging block (1 to 127).
    localparam int AVERAGE_COUNT = 100;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // floor(s / AVERAGE_COUNT) as (s * AVG_RECIP) >> RECIP_SHIFT, exact for any
    // block sum below 2**SUM_W.
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(AVERAGE_COUNT) - 64'd1) / 64'(AVERAGE_COUNT));
    localparam int AVG_PROD_W = SUM_W + RECIP_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_TIMEOUT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16     = 2'd3;

    localparam logic [TRIG_W-1:0]  RST_TRIGGER_TICKS = 8'd10;
    localparam logic [CNT_W-1:0]   RST_RISE_TIMEOUT  = 16'd10000;
    localparam logic [CNT_W-1:0]   RST_FALL_TIMEOUT  = 16'd50000;
    localparam logic [SCALE_W-1:0] RST_SCALE_Q16     = 16'd557;

    // Per-word status carried down the pipeline.
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
    } t_flags;

endpackage

@@ hdl/uer_ctrl.sv @@
// Measurement sequencer: trigger, rise wait and echo width timing per tick.
module uer_ctrl import uer_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [TRIG_W-1:0]  i_trigger_ticks,
    input  logic [CNT_W-1:0]   i_rise_timeout_ticks,
    input  logic [CNT_W-1:0]   i_fall_timeout_ticks,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_start_req,
    input  logic               i_echo,
    output logic               o_valid,
    input  logic               i_ready,
    output t_flags             o_flags,
    output logic [CNT_W-1:0]   o_width
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_RISE = 2'd2;
    localparam logic [1:0] PH_FALL = 2'd3;

    logic [1:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_tick, n_tick;
    logic [CNT_W-1:0] r_pw, n_pw;
    logic [CNT_W-1:0] tick_inc, pw_inc, width;
    logic             done, accept;
    logic             r1_vld;
    t_flags           r1_flags;
    logic [CNT_W-1:0] r1_width;

    assign tick_inc = r_tick + CNT_W'(1);
    assign pw_inc   = (r_pw != '1) ? r_pw + CNT_W'(1) : r_pw;

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_pw    = r_pw;
        done    = 1'b0;
        width   = r_pw;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_phase = PH_TRIG;
                    n_tick  = '0;
                end
            end
            PH_TRIG: begin
                n_tick = tick_inc;
                if ((CNT_W+1)'(tick_inc) + (CNT_W+1)'(1) >= (CNT_W+1)'(i_trigger_ticks)) begin
                    n_phase = PH_RISE;
                    n_tick  = '0;
                end
            end
            PH_RISE: begin
                if (i_echo) begin
                    n_phase = PH_FALL;
                    n_pw    = CNT_W'(1);
                    n_tick  = '0;
                    width   = CNT_W'(1);
                    done    = (CNT_W'(1) >= i_fall_timeout_ticks);
                end else begin
                    n_tick = tick_inc;
                    if (tick_inc >= i_rise_timeout_ticks || tick_inc == '0) begin
                        n_pw  = '0;
                        width = '0;
                        done  = 1'b1;
                    end
                end
            end
            PH_FALL: begin
                if (!i_echo) begin
                    done = 1'b1;
                end else begin
                    n_pw  = pw_inc;
                    width = pw_inc;
                    done  = (pw_inc >= i_fall_timeout_ticks) || (pw_inc == '1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (done) begin
            n_phase = PH_IDLE;
            n_tick  = '0;
        end
    end

    assign o_ready = !r1_vld || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_pw    <= '0;
            r1_vld  <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_pw    <= n_pw;
                r1_vld  <= 1'b1;
            end else if (i_ready) begin
                r1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_flags.trig <= (n_phase == PH_TRIG);
            r1_flags.busy <= (n_phase != PH_IDLE);
            r1_flags.done <= done;
            r1_width      <= width;
        end
    end

    assign o_valid = r1_vld;
    assign o_flags = r1_flags;
    assign o_width = r1_width;

    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick == '0))
        else $error("tick count not cleared in idle");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_vld && r1_flags.trig) |-> (r1_flags.busy && !r1_flags.done))
        else $error("trigger word without busy or with done");

endmodule

@@ hdl/uer_scale.sv @@
// Width to distance scaling, saturation and block accumulation.
module uer_scale import uer_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SCALE_W-1:0] i_scale_q16,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_flags             i_flags,
    input  logic [CNT_W-1:0]   i_width,
    output logic               o_valid,
    input  logic               i_ready,
    output t_flags             o_flags,
    output logic [DIST_W-1:0]  o_distance,
    output logic               o_avg_fire,
    output logic [SUM_W-1:0]   o_div_sum
);

    logic                  r2_vld;
    t_flags                r2_flags;
    logic [PROD_W-1:0]     r2_prod;
    logic                  r3_vld;
    t_flags                r3_flags;
    logic [DIST_W-1:0]     r3_dist;
    logic                  r3_fire;
    logic [SUM_W-1:0]      r3_div_sum;

    logic [DIST_W-1:0]     r_last, n_last;
    logic [SUM_W-1:0]      r_sum, n_sum, sum_add;
    logic [IDX_W-1:0]      r_idx, n_idx, idx_inc;
    logic [PROD_W-FRAC_SHIFT-1:0] shifted;
    logic [DIST_W-1:0]     sat;
    logic                  fire, s3_rdy, mv2, mv3;

    assign s3_rdy  = !r3_vld || i_ready;
    assign o_ready = !r2_vld || s3_rdy;
    assign mv2     = i_valid && o_ready;
    assign mv3     = r2_vld && s3_rdy;

    assign shifted = r2_prod[PROD_W-1:FRAC_SHIFT];
    assign sat     = (shifted > (PROD_W-FRAC_SHIFT)'(DIST_MAX)) ? DIST_MAX
                                                                : shifted[DIST_W-1:0];
    assign sum_add = r_sum + SUM_W'(sat);
    assign idx_inc = r_idx + IDX_W'(1);

    always_comb begin
        n_last = r_last;
        n_sum  = r_sum;
        n_idx  = r_idx;
        fire   = 1'b0;
        if (r2_flags.done) begin
            n_last = sat;
            if (idx_inc >= IDX_W'(AVERAGE_COUNT)) begin
                fire  = 1'b1;
                n_sum = '0;
                n_idx = '0;
            end else begin
                n_sum = sum_add;
                n_idx = idx_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r_last <= '0;
            r_sum  <= '0;
            r_idx  <= '0;
        end else begin
            if (mv2) begin
                r2_vld <= 1'b1;
            end else if (s3_rdy) begin
                r2_vld <= 1'b0;
            end
            if (mv3) begin
                r3_vld <= 1'b1;
                r_last <= n_last;
                r_sum  <= n_sum;
                r_idx  <= n_idx;
            end else if (i_ready) begin
                r3_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r2_flags <= i_flags;
            r2_prod  <= PROD_W'(i_width) * PROD_W'(i_scale_q16);
        end
        if (mv3) begin
            r3_flags   <= r2_flags;
            r3_dist    <= n_last;
            r3_fire    <= fire;
            r3_div_sum <= sum_add;
        end
    end

    assign o_valid    = r3_vld;
    assign o_flags    = r3_flags;
    assign o_distance = r3_dist;
    assign o_avg_fire = r3_fire;
    assign o_div_sum  = r3_div_sum;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < IDX_W'(AVERAGE_COUNT))
        else $error("sample index beyond block length");

endmodule

@@ hdl/uer_avg.sv @@
// Block average by reciprocal multiply, and the result word register.
module uer_avg import uer_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_flags             i_flags,
    input  logic [DIST_W-1:0]  i_distance,
    input  logic               i_avg_fire,
    input  logic [SUM_W-1:0]   i_div_sum,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_trigger,
    output logic               o_busy_res,
    output logic               o_sample_done,
    output logic [DIST_W-1:0]  o_distance,
    output logic               o_average_done,
    output logic [DIST_W-1:0]  o_average
);

    logic                  r4_vld;
    t_flags                r4_flags;
    logic [DIST_W-1:0]     r4_dist;
    logic                  r4_fire;
    logic [AVG_PROD_W-1:0] r4_prod;
    logic                  r_out_vld;
    t_flags                r_out_flags;
    logic [DIST_W-1:0]     r_out_dist;
    logic                  r_out_fire;
    logic [DIST_W-1:0]     r_avg;
    logic                  out_rdy, mv4, mv5;

    assign out_rdy = !r_out_vld || i_ready;
    assign o_ready = !r4_vld || out_rdy;
    assign mv4     = i_valid && o_ready;
    assign mv5     = r4_vld && out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld    <= 1'b0;
            r_out_vld <= 1'b0;
            r_avg     <= '0;
        end else begin
            if (mv4) begin
                r4_vld <= 1'b1;
            end else if (out_rdy) begin
                r4_vld <= 1'b0;
            end
            if (mv5) begin
                r_out_vld <= 1'b1;
                if (r4_fire) begin
                    r_avg <= r4_prod[RECIP_SHIFT +: DIST_W];
                end
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv4) begin
            r4_flags <= i_flags;
            r4_dist  <= i_distance;
            r4_fire  <= i_avg_fire;
            r4_prod  <= AVG_PROD_W'(i_div_sum) * AVG_PROD_W'(AVG_RECIP);
        end
        if (mv5) begin
            r_out_flags <= r4_flags;
            r_out_dist  <= r4_dist;
            r_out_fire  <= r4_fire;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_trigger      = r_out_flags.trig;
    assign o_busy_res     = r_out_flags.busy;
    assign o_sample_done  = r_out_flags.done;
    assign o_distance     = r_out_dist;
    assign o_average_done = r_out_fire;
    assign o_average      = r_avg;

endmodule

@@ hdl/ultrasonic_echo_ranger_avg.sv @@
// Top level of the ultrasonic echo ranger with block averaging.
//
// Each input word is one microsecond tick carrying a start request and the
// sampled echo pin. Each tick yields exactly one result word with the trigger
// drive, the busy flag, the completion pulses, the latest distance and the
// latest block average (both in 1/256 cm). A start in idle drives the trigger;
// trigger_ticks sets how long. The echo rise is then awaited for up to
// rise_timeout_ticks (a timeout gives width zero), and the echo high time is
// counted up to fall_timeout_ticks. Distance = floor(width * scale_q16 / 256),
// saturated at 131071. Every AVERAGE_COUNT distances the average is updated
// and the sum cleared. The block takes one word per clock while the output
// does not stall. Its two loops, the sequencer state update and the block
// accumulator, each close combinationally in their own registers. An accepted
// word passes five registers: sequencer, width multiplier, accumulator,
// reciprocal multiplier for the average, output register. A stall at the
// output holds its result word back. Each stage has its own valid bit, so
// words keep flowing into empty stages while a result waits at the output.
// Write the configuration registers only while no word is in flight.
module ultrasonic_echo_ranger_avg import uer_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // tick input
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_start_req,
    input  logic                 i_echo,
    // result output
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_trigger,
    output logic                 o_busy_res,
    output logic                 o_sample_done,
    output logic [DIST_W-1:0]    o_distance,
    output logic                 o_average_done,
    output logic [DIST_W-1:0]    o_average
);

    logic [TRIG_W-1:0]  r_trigger_ticks;
    logic [CNT_W-1:0]   r_rise_timeout;
    logic [CNT_W-1:0]   r_fall_timeout;
    logic [SCALE_W-1:0] r_scale_q16;

    // sequencer to scaler
    logic               seq_vld, seq_rdy;
    t_flags             seq_flags;
    logic [CNT_W-1:0]   seq_width;
    // scaler to averager
    logic               acc_vld, acc_rdy;
    t_flags             acc_flags;
    logic [DIST_W-1:0]  acc_dist;
    logic               acc_fire;
    logic [SUM_W-1:0]   acc_sum;

    // Configuration registers: plain writes, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= RST_TRIGGER_TICKS;
            r_rise_timeout  <= RST_RISE_TIMEOUT;
            r_fall_timeout  <= RST_FALL_TIMEOUT;
            r_scale_q16     <= RST_SCALE_Q16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRIGGER_TICKS: r_trigger_ticks <= i_cfg_data[TRIG_W-1:0];
                CFG_RISE_TIMEOUT:  r_rise_timeout  <= i_cfg_data[CNT_W-1:0];
                CFG_FALL_TIMEOUT:  r_fall_timeout  <= i_cfg_data[CNT_W-1:0];
                CFG_SCALE_Q16:     r_scale_q16     <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: advance the measurement phase once per accepted word.
    uer_ctrl u_ctrl (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_trigger_ticks      (r_trigger_ticks),
        .i_rise_timeout_ticks (r_rise_timeout),
        .i_fall_timeout_ticks (r_fall_timeout),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_start_req          (i_start_req),
        .i_echo               (i_echo),
        .o_valid              (seq_vld),
        .i_ready              (seq_rdy),
        .o_flags              (seq_flags),
        .o_width              (seq_width)
    );

    // Scale the width and fold completed distances into the block sum.
    uer_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scale_q16 (r_scale_q16),
        .i_valid     (seq_vld),
        .o_ready     (seq_rdy),
        .i_flags     (seq_flags),
        .i_width     (seq_width),
        .o_valid     (acc_vld),
        .i_ready     (acc_rdy),
        .o_flags     (acc_flags),
        .o_distance  (acc_dist),
        .o_avg_fire  (acc_fire),
        .o_div_sum   (acc_sum)
    );

    // Divide the closed block sum and hold the result word.
    uer_avg u_avg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (acc_vld),
        .o_ready        (acc_rdy),
        .i_flags        (acc_flags),
        .i_distance     (acc_dist),
        .i_avg_fire     (acc_fire),
        .i_div_sum      (acc_sum),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_trigger      (o_trigger),
        .o_busy_res     (o_busy_res),
        .o_sample_done  (o_sample_done),
        .o_distance     (o_distance),
        .o_average_done (o_average_done),
        .o_average      (o_average)
    );

    // A completing tick always returns the sequencer to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sample_done) |-> (!o_busy_res && !o_trigger))
        else $error("completion word still busy");

    // The average only moves on a tick that also completes a measurement.
    a_avg_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_average_done) |-> o_sample_done)
        else $error("average update without a completed measurement");

endmodule
